/* rtl/core/idet_pkg.sv */
// Shared types and constants for the integer matrix determinant block.
package idet_pkg;

   localparam int MAX_ORDER_DEF = 8;
   localparam int ENTRY_W       = 32;
   localparam int SIZE_W        = 4;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_MREAD,
      ST_MWAIT,
      ST_COL,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/idet_if.sv */
// Valid/ready channel interfaces for matrix entries and determinant results.
interface idet_req_if import idet_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] entry_value;
   logic               entry_last;

   modport source (output valid, output entry_value, output entry_last, input ready);
   modport sink (input valid, input entry_value, input entry_last, output ready);
endinterface

interface idet_rsp_if import idet_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] determinant;

   modport source (output valid, output determinant, input ready);
   modport sink (input valid, input determinant, output ready);
endinterface

/* rtl/core/idet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module idet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/integer_matrix_determinant.sv */
// Top level: integer matrix determinant by a subset dynamic program on one multiplier.
//
//  channel | direction | transfer                   | payload
//  req_if  | in        | one matrix entry           | entry_value[31:0], entry_last
//  rsp_if  | out       | one determinant            | determinant[31:0]
//  csr     | in        | write of matrix_size       | csr_wr_data[3:0]
//
// Entries are taken one per cycle while loading. After the entry marked last
// the block drops req ready and walks all column subsets of the first rows,
// one multiply-accumulate into the subset store at a time, all on the single
// shared multiplier and the one read and one write port of the subset store.
// Reset (synchronous, active high) returns to loading with matrix_size 1.
// A result waits in its register until taken; the block loads again after.
module integer_matrix_determinant import idet_pkg::*; #(
   parameter int MAX_ORDER = MAX_ORDER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   idet_req_if.sink          req_if,
   idet_rsp_if.source        rsp_if,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);
   localparam int OW    = $clog2(MAX_ORDER + 1);      // order and column counter
   localparam int SD    = MAX_ORDER * MAX_ORDER;      // matrix store depth
   localparam int SW    = $clog2(SD);                 // matrix store address
   localparam int LW    = $clog2(SD + 1);             // load index, holds SD
   localparam int MW    = MAX_ORDER;                  // column subset mask
   localparam int PD    = 1 << MAX_ORDER;             // subset store depth

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  matrix_size_ff;
   logic [LW-1:0]      load_idx_ff, load_idx_in;
   logic [MW-1:0]      mask_ff, mask_in;
   logic [OW-1:0]      col_ff, col_in;
   logic [OW-1:0]      row_ff, row_in;
   logic [MW-1:0]      tgt_ff, tgt_in;
   logic               neg_ff, neg_in;
   logic [ENTRY_W-1:0] acc_ff, acc_in;
   logic [ENTRY_W-1:0] term_ff, term_in;
   logic [ENTRY_W-1:0] old_ff, old_in;
   logic [ENTRY_W-1:0] result_ff, result_in;
   logic [PD-1:0]      valid_ff, valid_in;

   logic [OW-1:0]      order;
   logic [LW-1:0]      limit;
   logic [MW-1:0]      full_mask;
   logic [MW-1:0]      col_bit;
   logic               col_used;
   logic               parity;
   logic [OW-1:0]      mask_pop;
   logic [LW-1:0]      elem_addr;

   logic               st_wr_en;
   logic [SW-1:0]      st_rd_addr;
   logic [ENTRY_W-1:0] st_rd_data;
   logic               pt_wr_en;
   logic [MW-1:0]      pt_rd_addr;
   logic [ENTRY_W-1:0] pt_rd_data;
   logic [ENTRY_W-1:0] pt_wr_data;

   // Clamp the configured size into 1..MAX_ORDER.
   always_comb begin
      if (matrix_size_ff == '0) begin
         order = OW'(1);
      end else if (32'(matrix_size_ff) > MAX_ORDER) begin
         order = OW'(MAX_ORDER);
      end else begin
         order = OW'(matrix_size_ff);
      end
   end

   assign limit     = LW'(order) * LW'(order);
   assign full_mask = MW'((PD'(1) << order) - PD'(1));
   assign col_bit   = MW'(1) << col_ff;
   assign col_used  = |(mask_ff & col_bit);
   // Inversions added by column col: used columns to its right.
   assign parity    = ^(mask_ff >> (col_ff + OW'(1)));
   assign elem_addr = LW'(row_ff) * LW'(order) + LW'(col_ff);

   always_comb begin
      mask_pop = '0;
      for (int i = 0; i < MW; i++) begin
         mask_pop = mask_pop + OW'(mask_ff[i]);
      end
   end

   idet_ram #(.WIDTH(ENTRY_W), .DEPTH(SD)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (load_idx_ff[SW-1:0]),
      .wr_data (req_if.entry_value),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   idet_ram #(.WIDTH(ENTRY_W), .DEPTH(PD)) u_partial (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   assign pt_wr_data   = neg_ff ? (old_ff - term_ff) : (old_ff + term_ff);
   assign req_if.ready = (state_ff == ST_LOAD);
   assign rsp_if.valid = (state_ff == ST_DONE);
   assign rsp_if.determinant = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         matrix_size_ff <= SIZE_W'(1);
         load_idx_ff    <= '0;
         valid_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         load_idx_ff <= load_idx_in;
         valid_ff    <= valid_in;
         if (csr_wr_en) begin
            matrix_size_ff <= csr_wr_data;
         end
      end
      mask_ff   <= mask_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      tgt_ff    <= tgt_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      term_ff   <= term_in;
      old_ff    <= old_in;
      result_ff <= result_in;
   end

   always_comb begin
      state_in    = state_ff;
      load_idx_in = load_idx_ff;
      valid_in    = valid_ff;
      mask_in     = mask_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      tgt_in      = tgt_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      term_in     = term_ff;
      old_in      = old_ff;
      result_in   = result_ff;
      st_wr_en    = 1'b0;
      st_rd_addr  = elem_addr[SW-1:0];
      pt_wr_en    = 1'b0;
      pt_rd_addr  = mask_ff | col_bit;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_if.valid) begin
               // Store while in range, hold the index once the matrix is full.
               if (load_idx_ff < limit) begin
                  st_wr_en    = 1'b1;
                  load_idx_in = load_idx_ff + LW'(1);
               end
               if (req_if.entry_last) begin
                  load_idx_in = '0;
                  state_in    = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            valid_in = '0;
            mask_in  = '0;
            state_in = ST_MREAD;
         end
         ST_MREAD: begin
            pt_rd_addr = mask_ff;
            state_in   = ST_MWAIT;
         end
         ST_MWAIT: begin
            // Empty set seeds with one; unwritten subsets count as zero.
            if (mask_ff == '0) begin
               acc_in = ENTRY_W'(1);
            end else if (valid_ff[mask_ff]) begin
               acc_in = pt_rd_data;
            end else begin
               acc_in = '0;
            end
            row_in = mask_pop;
            col_in = '0;
            if (mask_ff == full_mask) begin
               result_in = acc_in;
               state_in  = ST_DONE;
            end else if (acc_in == '0) begin
               mask_in  = mask_ff + MW'(1);
               state_in = ST_MREAD;
            end else begin
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            if (col_ff == order) begin
               mask_in  = mask_ff + MW'(1);
               state_in = ST_MREAD;
            end else if (col_used) begin
               col_in = col_ff + OW'(1);
            end else begin
               tgt_in   = mask_ff | col_bit;
               neg_in   = parity;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            term_in  = ENTRY_W'(acc_ff * st_rd_data);
            old_in   = valid_ff[tgt_ff] ? pt_rd_data : '0;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            pt_wr_en         = 1'b1;
            valid_in[tgt_ff] = 1'b1;
            col_in           = col_ff + OW'(1);
            state_in         = ST_COL;
         end
         ST_DONE: begin
            if (rsp_if.ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

/* rtl/core/idet_checker.sv */
// Port-level checker for the determinant block, with its bind.
module idet_checker import idet_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [ENTRY_W-1:0] determinant
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> !req_ready)
      else $error("input taken after last entry");

   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(determinant))
      else $error("result dropped or changed while stalled");

   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready && !rsp_valid)
      else $error("block did not return to loading");
endmodule

bind integer_matrix_determinant idet_checker u_idet_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_last    (req_if.entry_last),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .determinant (rsp_if.determinant)
);

/* test/testbench.sv */
// Self-checking testbench for the integer matrix determinant block.
`timescale 1ns / 1ps

module testbench;
   import idet_pkg::*;

   // Directed stimulus: one row per matrix, expected value typed in where obvious.
   typedef struct {
      logic [SIZE_W-1:0] size_code;
      logic [31:0]       fill;
      logic              use_fill;
      logic              known;
      logic [31:0]       det_known;
   } matrix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;

   idet_req_if req_if ();
   idet_rsp_if rsp_if ();

   integer_matrix_determinant DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if.sink),
      .rsp_if      (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the matrix being loaded and the order in use.
   logic [31:0] entry_store [64];
   int          order_now;
   int          fill_pos;
   logic [31:0] det_queue [$];
   int          error_count = 0;
   longint      cycle_count = 0;
   logic        send_done = 1'b0;

   matrix_row_type dir_rows [] = '{
      '{4'd1, 32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff},
      '{4'd1, 32'h80000000, 1'b1, 1'b1, 32'h80000000},
      '{4'd0, 32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
      '{4'd2, 32'd5,        1'b1, 1'b1, 32'd0},
      '{4'd8, 32'h80000000, 1'b1, 1'b1, 32'd0},
      '{4'd15, 32'd0,       1'b0, 1'b0, 32'd0},
      '{4'd3, 32'd0,        1'b0, 1'b0, 32'd0},
      '{4'd2, 32'd0,        1'b0, 1'b0, 32'd0}
   };

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Subset dynamic program over columns; wraps modulo 2^32.
   function automatic logic [31:0] determinant_predict(int n);
      logic [31:0] sums [256];
      logic [31:0] term;
      int          row;
      int          above;
      for (int m = 0; m < 256; m++) sums[m] = '0;
      sums[0] = 32'd1;
      for (int m = 0; m < (1 << n) - 1; m++) begin
         row = $countones(m);
         for (int c = 0; c < n; c++) begin
            if (!m[c]) begin
               term  = sums[m] * entry_store[row * n + c];
               above = $countones(m >> (c + 1));
               if (above[0]) sums[m | (1 << c)] -= term;
               else          sums[m | (1 << c)] += term;
            end
         end
      end
      return sums[(1 << n) - 1];
   endfunction

   function automatic int order_of(logic [SIZE_W-1:0] code);
      if (code == 0) return 1;
      if (code > 8) return 8;
      return code;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Write the size register while idle; let the block settle first.
   task automatic write_size(logic [SIZE_W-1:0] code);
      wait (det_queue.size() == 0);
      repeat (2200) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      order_now = order_of(code);
   endtask

   // Transfer one entry, honoring bursts and gaps on the sender side.
   task automatic send_entry(logic [31:0] value, logic last);
      if ($urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.entry_value <= value;
      req_if.entry_last  <= last;
      do @(posedge clock); while (!req_if.ready);
      if (fill_pos < order_now * order_now) begin
         entry_store[fill_pos] = value;
         fill_pos++;
      end
      // Drop valid after the last entry; the block is busy for the next cycle.
      if (last) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_entry();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 7) - 3;
         1: return 32'h80000000;
         2: return 32'h7fffffff;
         default: return $urandom;
      endcase
   endfunction

   // Load a full matrix (optionally with extra ignored entries) and queue its result.
   task automatic send_matrix(logic [31:0] fill, logic use_fill, logic known,
                              logic [31:0] det_known, int extra);
      int total;
      logic [31:0] v;
      total = order_now * order_now + extra;
      fill_pos = 0;
      for (int k = 0; k < total; k++) begin
         v = use_fill ? fill : random_entry();
         if (k == total - 1) begin
            // Store the final entry before predicting, then queue.
            if (fill_pos < order_now * order_now) entry_store[fill_pos] = v;
            det_queue.push_back(known ? det_known : determinant_predict(order_now));
            fill_pos = order_now * order_now;
         end
         send_entry(v, k == total - 1);
      end
   endtask

   // Result side: stall on its own pattern, compare each transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (cycle_count % 64 < 20) ? 1'b1 : ($urandom_range(0, 2) != 0);
         if (rsp_if.valid && rsp_if.ready) begin
            if (det_queue.size() == 0) begin
               report_mismatch("result with no matrix pending");
            end else begin
               if (rsp_if.determinant !== det_queue[0])
                  report_mismatch($sformatf("determinant %h expected %h",
                                  rsp_if.determinant, det_queue[0]));
               void'(det_queue.pop_front());
            end
         end
      end
   end

   initial begin
      int entries;
      int size_pick;
      req_if.valid       <= 1'b0;
      req_if.entry_value <= '0;
      req_if.entry_last  <= 1'b0;
      order_now = 1;
      for (int k = 0; k < 64; k++) entry_store[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // After reset the order is one.
      send_matrix(32'd9, 1'b1, 1'b1, 32'd9, 0);
      foreach (dir_rows[i]) begin
         write_size(dir_rows[i].size_code);
         send_matrix(dir_rows[i].fill, dir_rows[i].use_fill, dir_rows[i].known,
                     dir_rows[i].det_known, 0);
      end
      // Extra entries past n*n are dropped.
      send_matrix(32'd0, 1'b0, 1'b0, 32'd0, 3);
      // Random part: mostly small orders, a few large.
      entries = 0;
      while (entries < 900) begin
         size_pick = $urandom_range(0, 19);
         write_size(size_pick == 0 ? 4'($urandom_range(6, 15)) :
                    4'($urandom_range(0, 5)));
         for (int r = 0; r < 3; r++) begin
            send_matrix(32'd0, 1'b0, 1'b0, 32'd0,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            entries += order_now * order_now;
         end
      end
      send_done = 1'b1;
   end

   initial begin
      wait (send_done);
      wait (det_queue.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      wait (cycle_count >= 3000000);
      $display("status: fail");
      $finish;
   end
endmodule

/* files.f */
rtl/core/idet_pkg.sv
rtl/core/idet_if.sv
rtl/core/idet_ram.sv
rtl/core/integer_matrix_determinant.sv
rtl/core/idet_checker.sv
test/testbench.sv
